// ===== rtl/clock_tempo_tracker_top_defines.svh =====
// Assertion macros shared by the clock tempo tracker checkers.
// Depends on nothing; included by the checker file.
`ifndef CLOCK_TEMPO_TRACKER_TOP_DEFINES_SVH
`define CLOCK_TEMPO_TRACKER_TOP_DEFINES_SVH

// Property checked on every rising edge, ignored while reset is applied.
`define CTT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("clock tempo tracker assertion failed");

// Property checked on every rising edge, reset included.
`define CTT_ASSERT_NORST(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("clock tempo tracker assertion failed");

`endif

// ===== rtl/ctt_pkg.sv =====
// Shared types, constants and tempo helper functions of the clock tempo tracker.
// Depends on nothing; used by every RTL module of the block.
`default_nettype none

package ctt_pkg;

    localparam int FREQ_W     = 27;  // timer frequency register
    localparam int BPM_W      = 9;   // tempo in beats per minute
    localparam int GAP_W      = 32;  // count gaps and tick period
    localparam int F120_W     = 34;  // 120 * frequency
    localparam int NUM_W      = 35;  // divider dividend and quotient
    localparam int DIVR_W     = 33;  // divider divisor
    localparam int IDX_W      = 10;  // tick index port
    localparam int IN_W       = 8;   // input tdata
    localparam int OUT_W      = 24;  // output tdata
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 27;

    localparam logic [GAP_W-1:0] GAP_MAX = '1;

    localparam logic [BPM_W-1:0] BPM_MIN   = 9'd20;
    localparam logic [BPM_W-1:0] BPM_MAX   = 9'd500;
    localparam logic [BPM_W-1:0] BPM_RESET = 9'd120;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 27'd1000000;

    // Correction band edges of the measured tempo
    localparam logic [BPM_W:0] CORR_EDGE_1 = 10'd78;
    localparam logic [BPM_W:0] CORR_EDGE_2 = 10'd137;
    localparam logic [BPM_W:0] CORR_EDGE_3 = 10'd196;
    localparam logic [BPM_W:0] CORR_EDGE_4 = 10'd272;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERNAL_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERNAL_BPM  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_FREQ    = 2'd2;

    typedef struct packed {
        logic take_item;         // latch pulse flag, advance gap counters
        logic load_int_bpm;      // tempo from the internal register
        logic load_max_bpm;      // zero pulse gap: fastest tempo
        logic start_tempo_div;   // divide for the measured tempo
        logic start_period_div;  // divide for the tick period
        logic store_tempo;       // write corrected tempo, restart pulse gap
        logic store_period;      // write tick period
        logic commit_tick;       // tick test and load the result register
    } t_ctt_cmd;

    typedef struct packed {
        logic item_pulse;   // latched item carries a pulse
        logic int_mode;     // internal tempo selected
        logic gap_zero;     // pulse gap is zero
        logic div_done;     // divider quotient ready
        logic out_blocked;  // result register full and not taken
    } t_ctt_status;

    function automatic logic [BPM_W-1:0] clamp_bpm(input logic [BPM_W:0] v);
        if (v > {1'b0, BPM_MAX}) begin
            return BPM_MAX;
        end
        if (v < {1'b0, BPM_MIN}) begin
            return BPM_MIN;
        end
        return v[BPM_W-1:0];
    endfunction

    // Rounded tempo quotient to corrected, clamped tempo
    function automatic logic [BPM_W-1:0] correct_tempo(input logic [NUM_W-1:0] q);
        logic [BPM_W:0] b;
        logic [BPM_W:0] c;
        b = q[BPM_W:0];
        if (q > NUM_W'(BPM_MAX)) begin
            return BPM_MAX;
        end
        if (b >= CORR_EDGE_4) begin
            c = b + 10'd7;
        end else if (b >= CORR_EDGE_3) begin
            c = b + 10'd4;
        end else if (b >= CORR_EDGE_2) begin
            c = b + 10'd2;
        end else if (b >= CORR_EDGE_1) begin
            c = b + 10'd1;
        end else begin
            c = b;
        end
        return clamp_bpm(c);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ctt_div.sv =====
// Restoring divider, one quotient bit per clock.
// Depends on ctt_pkg for operand widths.
`default_nettype none

module ctt_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ctt_pkg::NUM_W-1:0]  i_dividend,
    input  wire logic [ctt_pkg::DIVR_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [ctt_pkg::NUM_W-1:0]       o_quotient
);

    localparam int NUM_W  = ctt_pkg::NUM_W;
    localparam int DIVR_W = ctt_pkg::DIVR_W;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVR_W-1:0] r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [DIVR_W-1:0] r_dvs;

    logic [DIVR_W:0]   w_shift;
    logic [DIVR_W+1:0] w_diff;
    logic              w_fit;
    logic [DIVR_W-1:0] n_rem;
    logic [NUM_W-1:0]  n_quo;

    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b0, r_dvs};
        w_fit   = !w_diff[DIVR_W+1];
        n_rem   = w_fit ? w_diff[DIVR_W-1:0] : w_shift[DIVR_W-1:0];
        n_quo   = {r_quo[NUM_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/ctt_datapath.sv =====
// Datapath: configuration, gap counters, tempo and period math, tick counter, result register.
// Depends on ctt_pkg and ctt_div.
`default_nettype none

module ctt_datapath #(
    parameter int TICKS_PER_BAR = 96
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ctt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [ctt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_adv,
    input  wire logic                           i_pulse,
    input  wire ctt_pkg::t_ctt_cmd              i_cmd,
    input  wire logic                           i_m_tready,
    output ctt_pkg::t_ctt_status                o_status,
    output logic                                o_m_tvalid,
    output logic [ctt_pkg::OUT_W-1:0]           o_m_tdata
);

    localparam int FREQ_W = ctt_pkg::FREQ_W;
    localparam int BPM_W  = ctt_pkg::BPM_W;
    localparam int GAP_W  = ctt_pkg::GAP_W;
    localparam int F120_W = ctt_pkg::F120_W;
    localparam int NUM_W  = ctt_pkg::NUM_W;
    localparam int DIVR_W = ctt_pkg::DIVR_W;
    localparam int IDX_W  = ctt_pkg::IDX_W;
    localparam int OUT_W  = ctt_pkg::OUT_W;
    localparam int DEN_W  = BPM_W + IDX_W;
    localparam int PAD_W  = OUT_W - IDX_W - 2 - BPM_W;

    localparam logic [IDX_W-1:0] TPB = IDX_W'(TICKS_PER_BAR);

    logic              r_int_mode;
    logic [BPM_W-1:0]  r_int_bpm;
    logic [FREQ_W-1:0] r_freq;
    logic [F120_W-1:0] r_f120;
    logic [DEN_W-1:0]  r_den;
    logic              r_pulse;
    logic [GAP_W-1:0]  r_pulse_gap;
    logic [GAP_W-1:0]  r_tick_gap;
    logic [GAP_W-1:0]  r_period;
    logic [BPM_W-1:0]  r_bpm;
    logic [IDX_W-1:0]  r_pos;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [NUM_W-1:0]  w_tempo_num;
    logic [DIVR_W-1:0] w_tempo_den;
    logic [NUM_W-1:0]  w_period_num;
    logic [DIVR_W-1:0] w_period_den;
    logic              w_div_start;
    logic [NUM_W-1:0]  w_dividend;
    logic [DIVR_W-1:0] w_divisor;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quotient;
    logic [GAP_W-1:0]  w_period_sat;
    logic              w_hit;
    logic [IDX_W:0]    w_pos_inc;
    logic              w_wrap;
    logic [IDX_W-1:0]  n_pos;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_mode <= 1'b0;
            r_int_bpm  <= ctt_pkg::BPM_RESET;
            r_freq     <= ctt_pkg::FREQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ctt_pkg::CFG_INTERNAL_MODE: r_int_mode <= i_cfg_data[0];
                ctt_pkg::CFG_INTERNAL_BPM:  r_int_bpm  <= i_cfg_data[BPM_W-1:0];
                ctt_pkg::CFG_TIMER_FREQ:    r_freq     <= i_cfg_data[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    // Precomputed products: 120 * freq and ticks per bar * tempo
    always_ff @(posedge i_clk) begin
        r_f120 <= {r_freq, 7'b0} - {4'b0, r_freq, 3'b0};
        r_den  <= {{BPM_W{1'b0}}, TPB} * {{IDX_W{1'b0}}, r_bpm};
    end

    // Rounded tempo: (120 f + gap) / (2 gap); ceiled period: (240 f + den - 1) / den
    always_comb begin
        w_tempo_num  = NUM_W'(r_f120) + NUM_W'(r_pulse_gap);
        w_tempo_den  = {r_pulse_gap, 1'b0};
        w_period_num = {r_f120, 1'b0} + NUM_W'(r_den) - NUM_W'(1);
        w_period_den = DIVR_W'(r_den);
        w_div_start  = i_cmd.start_tempo_div | i_cmd.start_period_div;
        w_dividend   = i_cmd.start_tempo_div ? w_tempo_num : w_period_num;
        w_divisor    = i_cmd.start_tempo_div ? w_tempo_den : w_period_den;
    end

    ctt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        if (w_quotient[NUM_W-1:GAP_W] != '0) begin
            w_period_sat = ctt_pkg::GAP_MAX;
        end else begin
            w_period_sat = w_quotient[GAP_W-1:0];
        end
        w_hit     = (r_period != '0) && (r_tick_gap >= r_period);
        w_pos_inc = {1'b0, r_pos} + 1'b1;
        w_wrap    = w_pos_inc >= {1'b0, TPB};
        n_pos     = w_wrap ? '0 : w_pos_inc[IDX_W-1:0];
    end

    // Tempo state and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_gap <= '0;
            r_tick_gap  <= '0;
            r_period    <= '0;
            r_bpm       <= '0;
            r_pos       <= '0;
        end else begin
            if (i_cmd.take_item && i_adv) begin
                if (r_pulse_gap != ctt_pkg::GAP_MAX) begin
                    r_pulse_gap <= r_pulse_gap + 1'b1;
                end
                if (r_tick_gap != ctt_pkg::GAP_MAX) begin
                    r_tick_gap <= r_tick_gap + 1'b1;
                end
            end
            if (i_cmd.load_int_bpm) begin
                r_bpm <= ctt_pkg::clamp_bpm({1'b0, r_int_bpm});
            end
            if (i_cmd.load_max_bpm) begin
                r_bpm       <= ctt_pkg::BPM_MAX;
                r_pulse_gap <= '0;
            end
            if (i_cmd.store_tempo) begin
                r_bpm       <= ctt_pkg::correct_tempo(w_quotient);
                r_pulse_gap <= '0;
            end
            if (i_cmd.store_period) begin
                r_period <= w_period_sat;
            end
            if (i_cmd.commit_tick && w_hit) begin
                r_tick_gap <= '0;
                r_pos      <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_pulse <= i_pulse;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_tick) begin
            r_out_data <= {{PAD_W{1'b0}}, r_bpm, w_hit && w_wrap, w_hit,
                           w_hit ? n_pos : r_pos};
        end
    end

    always_comb begin
        o_status.item_pulse  = r_pulse;
        o_status.int_mode    = r_int_mode;
        o_status.gap_zero    = (r_pulse_gap == '0);
        o_status.div_done    = w_div_done;
        o_status.out_blocked = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/ctt_ctrl.sv =====
// Controller: sequences one item through tempo update, period update and tick test.
// Depends on ctt_pkg for the command and status structs.
`default_nettype none

module ctt_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire ctt_pkg::t_ctt_status i_status,
    output logic                      o_s_tready,
    output ctt_pkg::t_ctt_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE         = 3'd0;
    localparam logic [2:0] S_DECIDE       = 3'd1;
    localparam logic [2:0] S_TEMPO_DIV    = 3'd2;
    localparam logic [2:0] S_DEN          = 3'd3;
    localparam logic [2:0] S_PERIOD_START = 3'd4;
    localparam logic [2:0] S_PERIOD_DIV   = 3'd5;
    localparam logic [2:0] S_TICK         = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.int_mode) begin
                    o_cmd.load_int_bpm = 1'b1;
                    n_state            = S_DEN;
                end else if (i_status.item_pulse) begin
                    if (i_status.gap_zero) begin
                        o_cmd.load_max_bpm = 1'b1;
                        n_state            = S_DEN;
                    end else begin
                        o_cmd.start_tempo_div = 1'b1;
                        n_state               = S_TEMPO_DIV;
                    end
                end else begin
                    n_state = S_TICK;
                end
            end
            S_TEMPO_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.store_tempo = 1'b1;
                    n_state           = S_DEN;
                end
            end
            // let the registered tempo product settle before the period division
            S_DEN: begin
                n_state = S_PERIOD_START;
            end
            S_PERIOD_START: begin
                o_cmd.start_period_div = 1'b1;
                n_state                = S_PERIOD_DIV;
            end
            S_PERIOD_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.store_period = 1'b1;
                    n_state            = S_TICK;
                end
            end
            S_TICK: begin
                if (!i_status.out_blocked) begin
                    o_cmd.commit_tick = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/clock_tempo_tracker_top.sv =====
// Clock tempo tracker: one input transaction per system clock event, one result per input.
// An input without a tempo update skips the divider; internal mode and a pulse with zero
// gap run one division, and an external pulse runs two. The single shared restoring
// divider (one quotient bit per clock, 35 bits) runs once for the tick period and once
// more for a measured tempo. Each input carries a timer count step and an external
// quarter-note pulse flag. In external mode a pulse measures the counts since the
// previous pulse and turns them into a tempo, corrected and clamped to 20..500 bpm; in
// internal mode the tempo comes from a register. The tempo sets the tick period in
// counts, and the tick index advances modulo TICKS_PER_BAR, flagging the start of each
// bar. A new input is taken once the previous one is through, even while its result still
// waits in the output register. Configuration must be written only while the block is
// idle; the block does not enforce this. Depends on ctt_pkg, ctt_ctrl, ctt_datapath, ctt_div.
`default_nettype none

module clock_tempo_tracker_top #(
    parameter int TICKS_PER_BAR = 96  // ticks per bar, 4..960
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [ctt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [ctt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [0] timer_advance, [1] ext_pulse, [7:2] zero
    input  wire logic [ctt_pkg::IN_W-1:0]       i_s_axis_tdata,
    // output stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [9:0] tick_index, [10] tick_step, [11] bar_start, [20:12] tempo_bpm, [23:21] zero
    output logic [ctt_pkg::OUT_W-1:0]           o_m_axis_tdata
);

    ctt_pkg::t_ctt_cmd    w_cmd;
    ctt_pkg::t_ctt_status w_status;

    // Sequence each transaction: gap update, optional tempo and period divisions, tick test
    ctt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_s_tready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Hold configuration, counters, the shared divider and the result register
    ctt_datapath #(
        .TICKS_PER_BAR (TICKS_PER_BAR)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_adv      (i_s_axis_tdata[0]),
        .i_pulse    (i_s_axis_tdata[1]),
        .i_cmd      (w_cmd),
        .i_m_tready (i_m_axis_tready),
        .o_status   (w_status),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/ctt_checker.sv =====
// Port-level checker of the clock tempo tracker and its bind to the top level.
// Depends on clock_tempo_tracker_top_defines.svh and ctt_pkg.
`default_nettype none

`include "clock_tempo_tracker_top_defines.svh"

module ctt_port_asserts (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_tvalid,
    input wire logic                      i_s_tready,
    input wire logic                      i_m_tvalid,
    input wire logic                      i_m_tready,
    input wire logic [ctt_pkg::OUT_W-1:0] i_m_tdata
);

    logic [ctt_pkg::BPM_W-1:0] w_tempo;
    logic                      w_tempo_ok;
    logic                      w_stall;
    logic                      w_bar;
    logic                      w_wrap;

    assign w_tempo    = i_m_tdata[20:12];
    assign w_tempo_ok = (w_tempo == 9'd0) ||
                        ((w_tempo >= ctt_pkg::BPM_MIN) && (w_tempo <= ctt_pkg::BPM_MAX));
    assign w_stall    = i_m_tvalid && !i_m_tready;
    assign w_bar      = i_m_tdata[11];
    assign w_wrap     = i_m_tdata[10] && (i_m_tdata[9:0] == 10'd0);

    // Reset leaves no result pending and the input side open
    `CTT_ASSERT_NORST(a_reset_idle, i_clk, !i_rst_n |=> !i_m_tvalid && i_s_tready)
    // A stalled result holds
    `CTT_ASSERT(a_out_hold, i_clk, i_rst_n, w_stall |=> i_m_tvalid && $stable(i_m_tdata))
    // A bar start is a tick that lands on index zero
    `CTT_ASSERT(a_bar_is_wrap, i_clk, i_rst_n, i_m_tvalid && w_bar |-> w_wrap)
    // Tempo is unset or within the clamp range
    `CTT_ASSERT(a_tempo_range, i_clk, i_rst_n, i_m_tvalid |-> w_tempo_ok)
    // One transaction in work at a time
    `CTT_ASSERT(a_one_in_work, i_clk, i_rst_n, i_s_tvalid && i_s_tready |=> !i_s_tready)

endmodule

bind clock_tempo_tracker_top ctt_port_asserts u_ctt_port_asserts (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

`default_nettype wire
